/* hw/rtl/scm_pkg.sv */
package scm_pkg;

  // Field widths
  localparam int SAMPLE_WIDTH = 16;
  localparam int COLOR_WIDTH  = 8;   // 4..16
  localparam int GAIN_W       = 8;
  localparam int MODE_W       = 2;
  localparam int HEIGHT_W     = 16;  // 8.8 fixed point
  localparam int FRAC_W       = 8;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_COLOR_MODE  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT_GAIN = 1'd1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd10;

  localparam logic [COLOR_WIDTH-1:0] COLOR_MAX = '1;

  // Serial divider sizing: remainder wide enough for either divisor,
  // quotient wide enough for a height (COLOR_WIDTH never exceeds it).
  localparam int DIV_W  = (SAMPLE_WIDTH > COLOR_WIDTH) ? SAMPLE_WIDTH : COLOR_WIDTH;
  localparam int QUO_W  = HEIGHT_W;
  localparam int STEP_W = $clog2(QUO_W + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_GREY   = 2'd0,
    MODE_BLEND  = 2'd1,
    MODE_HUE    = 2'd2,
    MODE_HEIGHT = 2'd3
  } mode_t;

  // Divider load bundle
  typedef struct packed {
    logic [DIV_W-1:0]  rem0;     // upper dividend part, below the divisor
    logic [QUO_W-1:0]  low;      // lower dividend bits, MSB first
    logic [DIV_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;    // quotient bits to produce
  } div_req_t;

endpackage

/* hw/rtl/scm_if.sv */
interface scm_in_if
  import scm_pkg::*;
();
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic                           first;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, req_type, first, sample, input ready);
  modport sink   (input valid, req_type, first, sample, output ready);
endinterface

interface scm_out_if
  import scm_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [COLOR_WIDTH-1:0] red;
  logic [COLOR_WIDTH-1:0] green;
  logic [COLOR_WIDTH-1:0] blue;
  logic [HEIGHT_W-1:0]    height_out;
  logic                   degenerate;

  modport source (output valid, red, green, blue, height_out, degenerate, input ready);
  modport sink   (input valid, red, green, blue, height_out, degenerate, output ready);
endinterface

interface scm_cfg_if
  import scm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

/* hw/rtl/scm_div.sv */
// Restoring divider, one quotient bit per cycle.
module scm_div
  import scm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  div_req_t         req,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  logic [DIV_W-1:0]  rem;
  logic [QUO_W-1:0]  low;
  logic [DIV_W-1:0]  divisor;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic [DIV_W+1:0]  trial;

  // {rem, next bit} minus divisor; top bit set means it does not fit
  assign trial = {1'b0, rem, low[QUO_W-1]} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // pulse done on the cycle after the last quotient bit
      done <= busy && !start && (cnt == STEP_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= req.rem0;
      low     <= req.low;
      divisor <= req.divisor;
      quo     <= '0;
    end else if (busy) begin
      low <= {low[QUO_W-2:0], 1'b0};
      quo <= {quo[QUO_W-2:0], ~trial[DIV_W+1]};
      if (!trial[DIV_W+1]) begin
        rem <= trial[DIV_W-1:0];
      end else begin
        rem <= {rem[DIV_W-2:0], low[QUO_W-1]};
      end
    end
  end

endmodule

/* hw/rtl/scalar_colormap.sv */
// scalar_colormap: min/max-normalized color mapping of signed scalar samples.
// Send the data set twice. Measure items (req_type 0) update a running
// minimum and maximum and produce no result; first restarts both from the
// item's sample. Map items (req_type 1) produce one result each: the sample
// is normalized to t = floor(255*(s-min)/(max-min)), clamped to 0..255, and
// shown as grey, a red-to-green blend, a hue ramp from red (0 deg) to blue
// (240 deg), or, in height mode, a height of gain*t/255 in 8.8 format (the
// colors are then 0; in color modes the height is 0). If max does not exceed
// min, t is 0 and degenerate is set. A measure item is taken and the block
// is ready again at once. A map item holds the input while the block steps
// through the prepare and scale states, the bit-serial divider (one quotient
// bit per cycle) and the color state and, in height mode, the shift-add
// multiplier and a second pass through the same divider, then the output
// state. A sample clamped at either end skips the normalization divide. A
// finished result waits in the output register, so measure items keep
// flowing while it is not yet taken.
// Configuration writes are taken every cycle; send them only while idle.
module scalar_colormap
  import scm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  scm_in_if.sink     samples,
  scm_out_if.source  colors,
  scm_cfg_if.sink    cfg
);

  localparam int SCALED_W = SAMPLE_WIDTH + COLOR_WIDTH;
  localparam int PROD_W   = GAIN_W + COLOR_WIDTH;
  localparam int P_W      = COLOR_WIDTH + 2;
  localparam int MCNT_W   = $clog2(COLOR_WIDTH + 1);

  // Hue sector limits: multiples of the full color value
  localparam logic [P_W-1:0] LIM1 = P_W'(COLOR_MAX);
  localparam logic [P_W-1:0] LIM2 = LIM1 + LIM1;
  localparam logic [P_W-1:0] LIM3 = LIM2 + LIM1;
  localparam logic [P_W-1:0] LIM4 = LIM3 + LIM1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCALE,
    S_DIV,
    S_COLOR,
    S_MUL,
    S_HDIV,
    S_OUT
  } state_t;

  state_t state;

  // Configuration registers
  mode_t             color_mode;
  logic [GAIN_W-1:0] height_gain;

  // Running range
  logic signed [SAMPLE_WIDTH-1:0] min_seen;
  logic signed [SAMPLE_WIDTH-1:0] max_seen;

  // Per-item working registers
  logic signed [SAMPLE_WIDTH-1:0] smp;
  logic [SAMPLE_WIDTH-1:0]        num;
  logic [SAMPLE_WIDTH-1:0]        den;
  logic                           degen;
  logic [COLOR_WIDTH-1:0]         t;
  logic [PROD_W-1:0]              prod;
  logic [MCNT_W-1:0]              mcnt;
  logic [HEIGHT_W-1:0]            h_res;
  logic                           started;

  // Output register
  logic                   out_valid;
  logic [COLOR_WIDTH-1:0] red;
  logic [COLOR_WIDTH-1:0] green;
  logic [COLOR_WIDTH-1:0] blue;
  logic [HEIGHT_W-1:0]    height_out;
  logic                   degenerate;

  assign samples.ready     = (state == S_IDLE);
  assign cfg.ready         = 1'b1;
  assign colors.valid      = out_valid;
  assign colors.red        = red;
  assign colors.green      = green;
  assign colors.blue       = blue;
  assign colors.height_out = height_out;
  assign colors.degenerate = degenerate;

  // Range checks on the held sample
  logic signed [SAMPLE_WIDTH:0] s_ext, min_ext, max_ext, diff_s, diff_r;
  logic                         range_ok, at_low, at_high;

  always_comb begin
    s_ext    = {smp[SAMPLE_WIDTH-1], smp};
    min_ext  = {min_seen[SAMPLE_WIDTH-1], min_seen};
    max_ext  = {max_seen[SAMPLE_WIDTH-1], max_seen};
    diff_s   = s_ext - min_ext;
    diff_r   = max_ext - min_ext;
    range_ok = (max_seen > min_seen);
    at_low   = (smp <= min_seen);
    at_high  = (smp >= max_seen);
  end

  // Dividend 255*num as (num << w) - num
  logic [SCALED_W-1:0] dvd;
  assign dvd = (SCALED_W'(num) << COLOR_WIDTH) - SCALED_W'(num);

  // Divider hookup: normalization pass, then the height pass
  logic             div_start;
  div_req_t         div_req;
  logic             div_done;
  logic [QUO_W-1:0] div_quo;

  always_comb begin
    div_start = 1'b0;
    div_req   = '0;
    if (state == S_SCALE) begin
      div_start       = 1'b1;
      div_req.rem0    = DIV_W'(dvd[SCALED_W-1:COLOR_WIDTH]);
      div_req.low     = QUO_W'(dvd[COLOR_WIDTH-1:0]) << (QUO_W - COLOR_WIDTH);
      div_req.divisor = DIV_W'(den);
      div_req.steps   = STEP_W'(COLOR_WIDTH);
    end else if (state == S_HDIV && !started) begin
      div_start       = 1'b1;
      div_req.rem0    = DIV_W'(prod[PROD_W-1:FRAC_W]);
      div_req.low     = {prod[FRAC_W-1:0], {FRAC_W{1'b0}}};
      div_req.divisor = DIV_W'(COLOR_MAX);
      div_req.steps   = STEP_W'(HEIGHT_W);
    end
  end

  scm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Color for the current t
  logic [P_W-1:0]         p;
  logic [2:0]             sector;
  logic [P_W-1:0]         f_wide;
  logic [COLOR_WIDTH-1:0] f, x;
  logic [COLOR_WIDTH-1:0] r_next, g_next, b_next;

  always_comb begin
    p = {t, 2'b00};
    priority if (p >= LIM4) begin
      sector = 3'd4;
      f_wide = p - LIM4;
    end else if (p >= LIM3) begin
      sector = 3'd3;
      f_wide = p - LIM3;
    end else if (p >= LIM2) begin
      sector = 3'd2;
      f_wide = p - LIM2;
    end else if (p >= LIM1) begin
      sector = 3'd1;
      f_wide = p - LIM1;
    end else begin
      sector = 3'd0;
      f_wide = p;
    end
    f = f_wide[COLOR_WIDTH-1:0];
    x = sector[0] ? (COLOR_MAX - f) : f;

    r_next = '0;
    g_next = '0;
    b_next = '0;
    unique case (color_mode)
      MODE_GREY: begin
        r_next = t;
        g_next = t;
        b_next = t;
      end
      MODE_BLEND: begin
        r_next = COLOR_MAX - t;
        g_next = t;
      end
      MODE_HUE: begin
        unique case (sector)
          3'd0: begin
            r_next = COLOR_MAX;
            g_next = x;
          end
          3'd1: begin
            r_next = x;
            g_next = COLOR_MAX;
          end
          3'd2: begin
            g_next = COLOR_MAX;
            b_next = x;
          end
          3'd3: begin
            g_next = x;
            b_next = COLOR_MAX;
          end
          default: begin
            r_next = x;
            b_next = COLOR_MAX;
          end
        endcase
      end
      MODE_HEIGHT: begin
        // colors stay 0
      end
    endcase
  end

  // Shift-add step: add gain into the upper part, shift right
  logic [GAIN_W:0] mul_sum;
  assign mul_sum = {1'b0, prod[PROD_W-1:COLOR_WIDTH]}
                 + (prod[0] ? {1'b0, height_gain} : {(GAIN_W+1){1'b0}});

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode  <= MODE_GREY;
      height_gain <= GAIN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_COLOR_MODE:  color_mode  <= mode_t'(cfg.data[MODE_W-1:0]);
        REG_HEIGHT_GAIN: height_gain <= cfg.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      min_seen  <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      max_seen  <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      started   <= 1'b0;
    end else begin
      // drop the result once taken; in S_OUT the register is refilled or held
      if (colors.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            smp <= samples.sample;
            if (!samples.req_type) begin
              if (samples.first) begin
                min_seen <= samples.sample;
                max_seen <= samples.sample;
              end else begin
                if (samples.sample < min_seen) min_seen <= samples.sample;
                if (samples.sample > max_seen) max_seen <= samples.sample;
              end
            end else begin
              state <= S_PREP;
            end
          end
        end

        S_PREP: begin
          degen <= ~range_ok;
          num   <= diff_s[SAMPLE_WIDTH-1:0];
          den   <= diff_r[SAMPLE_WIDTH-1:0];
          priority if (!range_ok || at_low) begin
            t     <= '0;
            state <= S_COLOR;
          end else if (at_high) begin
            t     <= COLOR_MAX;
            state <= S_COLOR;
          end else begin
            state <= S_SCALE;
          end
        end

        S_SCALE: begin
          state <= S_DIV;
        end

        S_DIV: begin
          if (div_done) begin
            t     <= div_quo[COLOR_WIDTH-1:0];
            state <= S_COLOR;
          end
        end

        S_COLOR: begin
          if (color_mode == MODE_HEIGHT) begin
            prod  <= PROD_W'(t);
            mcnt  <= MCNT_W'(COLOR_WIDTH);
            state <= S_MUL;
          end else begin
            h_res <= '0;
            state <= S_OUT;
          end
        end

        S_MUL: begin
          prod <= {mul_sum, prod[COLOR_WIDTH-1:1]};
          mcnt <= mcnt - 1'b1;
          if (mcnt == MCNT_W'(1)) begin
            started <= 1'b0;
            state   <= S_HDIV;
          end
        end

        S_HDIV: begin
          started <= 1'b1;
          if (started && div_done) begin
            h_res <= div_quo;
            state <= S_OUT;
          end
        end

        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || colors.ready) begin
            red        <= r_next;
            green      <= g_next;
            blue       <= b_next;
            height_out <= h_res;
            degenerate <= degen;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench
  import scm_pkg::*;
();

  // Request codes carried by req_type
  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_MAP     = 1'b1;

  localparam int ITEM_TARGET   = 1900;
  localparam int RANDOM_PHASES = 8;
  // A height map holds the input longest; leave a margin on top.
  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD     = 400;
  localparam int IDLE_LIMIT    = 5000;
  localparam int MAX_REPORTS   = 10;

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_TOP =
    {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_BOT =
    {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [COLOR_WIDTH-1:0] red;
    logic [COLOR_WIDTH-1:0] green;
    logic [COLOR_WIDTH-1:0] blue;
    logic [HEIGHT_W-1:0]    height;
    logic                   degenerate;
  } color_item_t;

  logic clk;
  logic rst;

  scm_in_if  samples_if ();
  scm_out_if colors_if ();
  scm_cfg_if cfg_if ();

  scalar_colormap u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .colors  (colors_if),
    .cfg     (cfg_if)
  );

  // Shadow copy of the block: measured range and the two registers.
  logic signed [SAMPLE_WIDTH-1:0] meas_min;
  logic signed [SAMPLE_WIDTH-1:0] meas_max;
  mode_t                          cur_mode;
  logic [GAIN_W-1:0]              cur_gain;

  // Colors still owed by the block, oldest first
  color_item_t pending_colors[$];

  int items_sent     = 0;
  int mismatches     = 0;
  int idle_cycles    = 0;
  int long_hold_left = 0;
  int stall_left     = 0;
  bit in_gaps_on     = 1'b0;
  bit out_stalls_on  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int rand16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Saturate an integer into the signed sample range.
  function automatic logic signed [SAMPLE_WIDTH-1:0] clip16(int v);
    if (v > int'(SAMPLE_TOP)) return SAMPLE_TOP;
    if (v < int'(SAMPLE_BOT)) return SAMPLE_BOT;
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  // Normalize a sample against the measured range and color it for the
  // current mode.
  function automatic color_item_t predict_color(logic signed [SAMPLE_WIDTH-1:0] s);
    int t, p, sector, frac, x, cmax;
    color_item_t res;
    cmax = int'(COLOR_MAX);
    res  = '0;
    // An empty or single-valued range pins t to zero and flags it
    if (meas_max <= meas_min) begin
      res.degenerate = 1'b1;
      t = 0;
    end else if (s <= meas_min) begin
      t = 0;
    end else if (s >= meas_max) begin
      t = cmax;
    end else begin
      t = ((int'(s) - int'(meas_min)) * cmax) / (int'(meas_max) - int'(meas_min));
    end
    case (cur_mode)
      MODE_GREY: begin
        res.red   = COLOR_WIDTH'(t);
        res.green = COLOR_WIDTH'(t);
        res.blue  = COLOR_WIDTH'(t);
      end
      MODE_BLEND: begin
        res.red   = COLOR_WIDTH'(cmax - t);
        res.green = COLOR_WIDTH'(t);
      end
      MODE_HUE: begin
        // Hue 0..240 deg split into 60 deg sectors; the secondary component
        // rises in even sectors and falls in odd ones.
        p      = 4 * t;
        sector = p / cmax;
        frac   = p % cmax;
        x      = (sector % 2 == 1) ? cmax - frac : frac;
        case (sector)
          0: begin
            res.red   = COLOR_WIDTH'(cmax);
            res.green = COLOR_WIDTH'(x);
          end
          1: begin
            res.red   = COLOR_WIDTH'(x);
            res.green = COLOR_WIDTH'(cmax);
          end
          2: begin
            res.green = COLOR_WIDTH'(cmax);
            res.blue  = COLOR_WIDTH'(x);
          end
          3: begin
            res.green = COLOR_WIDTH'(x);
            res.blue  = COLOR_WIDTH'(cmax);
          end
          default: begin
            res.red  = COLOR_WIDTH'(x);
            res.blue = COLOR_WIDTH'(cmax);
          end
        endcase
      end
      default: begin
        res.height = HEIGHT_W'((int'(cur_gain) * t * 256) / cmax);
      end
    endcase
    return res;
  endfunction

  // Offer one item from a falling edge, update the shadow state when it is
  // taken, then, when gaps are on, idle for a random gap. Leave valid high
  // when there is no gap so back-to-back items never toggle it within one step.
  task automatic send_item(input logic req, input logic frst, input int value);
    logic signed [SAMPLE_WIDTH-1:0] s;
    int gap;
    s = clip16(value);
    samples_if.valid    <= 1'b1;
    samples_if.req_type <= req;
    samples_if.first    <= frst;
    samples_if.sample   <= s;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    if (req == REQ_MAP) begin
      pending_colors.push_back(predict_color(s));
    end else if (frst) begin
      meas_min = s;
      meas_max = s;
    end else begin
      if (s < meas_min) meas_min = s;
      if (s > meas_max) meas_max = s;
    end
    items_sent++;
    @(negedge clk);
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid, wait for every owed color, then let the block settle.
  // Returns on a falling edge.
  task automatic wait_idle();
    samples_if.valid <= 1'b0;
    wait (pending_colors.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write both registers back to back; call only while the block is idle.
  task automatic set_config(input mode_t mode, input logic [GAIN_W-1:0] gain);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= REG_COLOR_MODE;
    cfg_if.data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cur_mode = mode;
    @(negedge clk);
    cfg_if.addr <= REG_HEIGHT_GAIN;
    cfg_if.data <= CFG_DATA_W'(gain);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cur_gain = gain;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Right after reset: map with nothing measured, then measure without a
  // first flag so the lone sample becomes both min and max.
  task automatic test_unmeasured_range();
    send_item(REQ_MAP, 1'b0, 1234);
    send_item(REQ_MAP, 1'b1, -32768);
    send_item(REQ_MEASURE, 1'b0, 77);
    send_item(REQ_MAP, 1'b0, 77);
  endtask

  // Full-scale range in every mode, then a single-valued and a one-step range
  // with samples on and beyond both ends.
  task automatic test_mode_extremes();
    mode_t m;
    m = MODE_GREY;
    repeat (4) begin
      wait_idle();
      set_config(m, (m == MODE_HEIGHT) ? 8'd255 : 8'd10);
      if (m == MODE_GREY) begin
        send_item(REQ_MEASURE, 1'b1, -32768);
        send_item(REQ_MEASURE, 1'b0, 32767);
      end
      send_item(REQ_MAP, 1'b0, -32768);
      send_item(REQ_MAP, 1'b0, 32767);
      send_item(REQ_MAP, 1'b1, 0);
      m = m.next();
    end
    wait_idle();
    set_config(MODE_HEIGHT, 8'd0);
    send_item(REQ_MEASURE, 1'b1, 100);
    send_item(REQ_MEASURE, 1'b0, 100);
    send_item(REQ_MAP, 1'b0, 99);
    send_item(REQ_MAP, 1'b0, 101);
    send_item(REQ_MEASURE, 1'b0, 101);
    send_item(REQ_MAP, 1'b0, 100);
    send_item(REQ_MAP, 1'b0, 101);
  endtask

  // Hold the result side off for a long stretch while maps keep coming, so
  // the output register fills and the input stalls; then drain completely.
  task automatic test_output_backpressure();
    wait_idle();
    set_config(MODE_HEIGHT, GAIN_W'($urandom_range(1, 255)));
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    send_item(REQ_MEASURE, 1'b1, -500);
    send_item(REQ_MEASURE, 1'b0, 500);
    long_hold_left = LONG_HOLD;
    repeat (20) begin
      send_item(REQ_MAP, 1'b0, $urandom_range(0, 1200) - 600);
      if ($urandom_range(0, 2) == 0)
        send_item(REQ_MEASURE, 1'b0, $urandom_range(0, 1400) - 700);
    end
    wait_idle();
  endtask

  // One data set: mostly a measure pass followed by a map pass, sometimes
  // noise, a degenerate set, a map pass against the old range, or a measure
  // pass that only widens the old range.
  task automatic send_random_set();
    int kind, lo, hi, tmp, n, k, value;
    kind = $urandom_range(0, 9);
    case ($urandom_range(0, 3))
      0: begin
        lo = rand16();
        hi = rand16();
      end
      1: begin
        lo = rand16();
        hi = lo + $urandom_range(1, 16);
      end
      2: begin
        lo = rand16();
        hi = lo + $urandom_range(0, 2000);
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          lo = -32768;
          hi = rand16();
        end else begin
          lo = rand16();
          hi = 32767;
        end
      end
    endcase
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    if (hi > 32767) hi = 32767;

    if (kind == 0) begin
      repeat ($urandom_range(1, 3))
        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand16());
      return;
    end
    if (kind == 1) hi = lo;
    // kind 2 skips the measure pass; kind 3 never restarts the range
    if (kind != 2) begin
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++) begin
        value = (k == 0) ? lo : (k == 1) ? hi : lo + $urandom_range(0, hi - lo);
        send_item(REQ_MEASURE, (k == 0) && (kind != 3), value);
      end
    end
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        7:       value = lo - $urandom_range(0, 40);
        8:       value = hi + $urandom_range(0, 40);
        9:       value = rand16();
        default: value = lo + $urandom_range(0, hi - lo);
      endcase
      send_item(REQ_MAP, $urandom_range(0, 7) == 0, value);
    end
  endtask

  // Random sets over several register settings, with and without idling on
  // either side, pausing now and then until every owed color is back.
  task automatic test_random_sets();
    mode_t             phase_mode [RANDOM_PHASES];
    logic [GAIN_W-1:0] phase_gain [RANDOM_PHASES];
    int ph, phase_end;
    phase_mode = '{MODE_GREY, MODE_BLEND, MODE_HUE, MODE_HEIGHT,
                   MODE_HEIGHT, MODE_HUE, MODE_HEIGHT, MODE_BLEND};
    phase_gain = '{8'd10, 8'd0, 8'd255, 8'd255, 8'd0, 8'd1, 8'd0, 8'd128};
    phase_gain[6] = GAIN_W'($urandom_range(0, 255));
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      set_config(phase_mode[ph], phase_gain[ph]);
      in_gaps_on    = (ph != 2) && (ph != 6);
      out_stalls_on = (ph != 5) && (ph != 6);
      phase_end = items_sent + (ITEM_TARGET - items_sent) / (RANDOM_PHASES - ph);
      while (items_sent < phase_end) begin
        send_random_set();
        if ($urandom_range(0, 49) == 0) wait_idle();
      end
    end
  endtask

  // Result side readiness: a long hold when asked, else random stalls.
  initial begin
    colors_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_left > 0) begin
        colors_if.ready <= 1'b0;
        long_hold_left--;
      end else if (stall_left > 0) begin
        colors_if.ready <= 1'b0;
        stall_left--;
      end else begin
        colors_if.ready <= 1'b1;
        if (out_stalls_on) stall_left = pick_gap();
      end
    end
  end

  // Compare every taken color with the oldest one owed.
  always @(posedge clk) begin : check_colors
    color_item_t got, want;
    if (!rst && colors_if.valid && colors_if.ready) begin
      got = '{colors_if.red, colors_if.green, colors_if.blue,
              colors_if.height_out, colors_if.degenerate};
      if (pending_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected color r=%0d g=%0d b=%0d h=%0d degen=%0d",
                   got.red, got.green, got.blue, got.height, got.degenerate);
      end else begin
        want = pending_colors.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.height !== want.height ||
            got.degenerate !== want.degenerate) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"color mismatch: want r=%0d g=%0d b=%0d h=%0d degen=%0d,",
                      " got r=%0d g=%0d b=%0d h=%0d degen=%0d"},
                     want.red, want.green, want.blue, want.height, want.degenerate,
                     got.red, got.green, got.blue, got.height, got.degenerate);
        end
      end
    end
  end

  // Stop a hung run: count cycles in which no channel moves an item.
  always @(posedge clk) begin
    if ((samples_if.valid && samples_if.ready) || (colors_if.valid && colors_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst                 = 1'b1;
    samples_if.valid    = 1'b0;
    samples_if.req_type = REQ_MEASURE;
    samples_if.first    = 1'b0;
    samples_if.sample   = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.addr         = REG_COLOR_MODE;
    cfg_if.data         = '0;
    meas_min            = SAMPLE_TOP;
    meas_max            = SAMPLE_BOT;
    cur_mode            = MODE_GREY;
    cur_gain            = GAIN_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_unmeasured_range();
    test_mode_extremes();
    test_output_backpressure();
    test_random_sets();
    wait_idle();

    if (mismatches == 0 && pending_colors.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/scm_pkg.sv
hw/rtl/scm_if.sv
hw/rtl/scm_div.sv
hw/rtl/scalar_colormap.sv
tb/testbench.sv
